// File: src/spacl_pkg.sv
// ----------------------------------------------------------------------------
// Source prefix and port access check: shared definitions
// Table sizes, field widths, function codes and the controller/datapath
// command and status types.
// ----------------------------------------------------------------------------
package spacl_pkg;

  localparam int PREFIX_ENTRIES = 16;
  localparam int PORT_ENTRIES   = 16;
  localparam int SCAN_ENTRIES   = (PREFIX_ENTRIES > PORT_ENTRIES) ? PREFIX_ENTRIES
                                                                  : PORT_ENTRIES;

  // Index widths address the tables, count widths also hold the full depth.
  localparam int PIDX_W = (PREFIX_ENTRIES > 1) ? $clog2(PREFIX_ENTRIES) : 1;
  localparam int QIDX_W = (PORT_ENTRIES > 1) ? $clog2(PORT_ENTRIES) : 1;
  localparam int PCNT_W = $clog2(PREFIX_ENTRIES + 1);
  localparam int QCNT_W = $clog2(PORT_ENTRIES + 1);
  localparam int SCNT_W = $clog2(SCAN_ENTRIES + 1);

  localparam int FUNC_W  = 3;
  localparam int ADDR_W  = 32;
  localparam int PLEN_W  = 6;
  localparam int PROTO_W = 2;
  localparam int PORT_W  = 16;
  localparam int KEY_W   = PORT_W + 1;
  localparam int CNT_W   = 16;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 8;

  localparam logic [ADDR_W-1:0] ALL_ONES    = 32'hFFFF_FFFF;
  localparam logic [PLEN_W-1:0] FULL_PREFIX = 6'd32;
  localparam logic [CNT_W-1:0]  COUNTER_MAX = 16'hFFFF;

  localparam logic [FUNC_W-1:0] FUNC_ADD_SOURCE = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD_OPEN   = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_ADD_RSTR   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR      = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CHECK      = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_PAIR       = 3'd5;

  localparam logic [PROTO_W-1:0] PROTO_STREAM = 2'd0;
  localparam logic [PROTO_W-1:0] PROTO_DGRAM  = 2'd1;

  localparam logic KIND_ADDRESS = 1'b0;
  localparam logic KIND_PORT    = 1'b1;

  typedef struct packed {
    logic load;    // capture the input word
    logic exec;    // apply table updates, arm the scan
    logic step;    // compare one table entry
    logic finish;  // fold pair hits into the request totals
    logic emit;    // load the result register
  } spacl_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              proto_ok;
    logic              last;
    logic              scan_empty;
    logic              scan_done;
    logic              out_free;
  } spacl_stat_t;

endpackage

// File: src/spacl_ctrl.sv
// ----------------------------------------------------------------------------
// Access check controller
// Sequences one input word at a time: capture, execute, table scan,
// request update and result hand-off.
// ----------------------------------------------------------------------------
module spacl_ctrl import spacl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  spacl_stat_t stat_i,
  output spacl_cmd_t  cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXEC   = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_FINISH = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        if (stat_i.func == FUNC_CHECK) begin
          state_d = stat_i.scan_empty ? ST_EMIT : ST_SCAN;
        end else if (stat_i.func == FUNC_PAIR) begin
          if (!stat_i.proto_ok) begin
            // uncounted pair still closes the request
            state_d = stat_i.last ? ST_EMIT : ST_IDLE;
          end else begin
            state_d = stat_i.scan_empty ? ST_FINISH : ST_SCAN;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd_o.step = 1'b1;
        if (stat_i.scan_done) begin
          state_d = (stat_i.func == FUNC_CHECK) ? ST_EMIT : ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = stat_i.last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: src/spacl_dp.sv
// ----------------------------------------------------------------------------
// Access check datapath
// Holds the input word, the prefix and pair tables, the request totals,
// the scan counter and the result register.
// ----------------------------------------------------------------------------
module spacl_dp import spacl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  spacl_cmd_t            cmd_i,
  output spacl_stat_t           stat_o,
  input  logic [IN_DATA_W-1:0]  in_data_i,
  input  logic [FUNC_W-1:0]     in_func_i,
  input  logic                  in_last_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_DATA_W-1:0] out_data_o,
  output logic                  out_kind_o
);

  // captured word
  logic [FUNC_W-1:0]  func_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [PLEN_W-1:0]  plen_q;
  logic [PROTO_W-1:0] proto_q;
  logic [PORT_W-1:0]  port_q;
  logic               last_q;

  // tables
  logic [ADDR_W-1:0] pfx_addr_q [PREFIX_ENTRIES];
  logic [ADDR_W-1:0] pfx_mask_q [PREFIX_ENTRIES];
  logic [KEY_W-1:0]  open_q     [PORT_ENTRIES];
  logic [KEY_W-1:0]  rstr_q     [PORT_ENTRIES];
  logic [PCNT_W-1:0] pfx_cnt_q;
  logic [QCNT_W-1:0] open_cnt_q;
  logic [QCNT_W-1:0] rstr_cnt_q;
  logic              ovf_q;

  // request totals
  logic [CNT_W-1:0] req_q;
  logic [CNT_W-1:0] hits_q;
  logic             rhit_q;

  // scan
  logic [SCNT_W-1:0] idx_q;
  logic              found_q;
  logic [QCNT_W-1:0] open_sum_q;
  logic              rstr_any_q;

  // result register
  logic                  out_valid_q;
  logic                  out_kind_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  logic              proto_ok;
  logic [KEY_W-1:0]  key;
  logic [PLEN_W-1:0] plen_sat;
  logic [ADDR_W-1:0] new_mask;
  logic              pfx_full, open_full, rstr_full;
  logic [SCNT_W-1:0] limit;
  logic [SCNT_W-1:0] idx_next;
  logic [PIDX_W-1:0] pidx;
  logic [QIDX_W-1:0] qidx;
  logic              pfx_hit, open_hit, rstr_hit;
  logic [CNT_W:0]    hits_sum;
  logic              verdict;
  logic              out_free;

  assign proto_ok = (proto_q <= PROTO_DGRAM);
  assign key      = {proto_q[0], port_q};
  assign plen_sat = (plen_q > FULL_PREFIX) ? FULL_PREFIX : plen_q;
  assign new_mask = (plen_sat == '0) ? '0 : (ALL_ONES << (FULL_PREFIX - plen_sat));

  assign pfx_full  = (pfx_cnt_q == PCNT_W'(PREFIX_ENTRIES));
  assign open_full = (open_cnt_q == QCNT_W'(PORT_ENTRIES));
  assign rstr_full = (rstr_cnt_q == QCNT_W'(PORT_ENTRIES));

  always_comb begin
    if (func_q == FUNC_CHECK) begin
      limit = SCNT_W'(pfx_cnt_q);
    end else if (open_cnt_q > rstr_cnt_q) begin
      limit = SCNT_W'(open_cnt_q);
    end else begin
      limit = SCNT_W'(rstr_cnt_q);
    end
  end

  assign idx_next = SCNT_W'(idx_q + 1'b1);
  assign pidx     = idx_q[PIDX_W-1:0];
  assign qidx     = idx_q[QIDX_W-1:0];

  assign pfx_hit  = ((addr_q & pfx_mask_q[pidx]) == (pfx_addr_q[pidx] & pfx_mask_q[pidx]));
  assign open_hit = (idx_q < SCNT_W'(open_cnt_q)) && (open_q[qidx] == key);
  assign rstr_hit = (idx_q < SCNT_W'(rstr_cnt_q)) && (rstr_q[qidx] == key);

  assign hits_sum = {1'b0, hits_q} + (CNT_W + 1)'(open_sum_q);

  always_comb begin
    priority if (req_q == '0) begin
      verdict = 1'b0;
    end else if (rhit_q) begin
      verdict = 1'b0;
    end else if ((open_cnt_q != '0) && (hits_q != req_q)) begin
      verdict = 1'b0;
    end else begin
      verdict = 1'b1;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  // captured word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= in_func_i;
      addr_q  <= in_data_i[31:0];
      plen_q  <= in_data_i[37:32];
      proto_q <= in_data_i[39:38];
      port_q  <= in_data_i[55:40];
      last_q  <= in_last_i;
    end
  end

  // table contents
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      if ((func_q == FUNC_ADD_SOURCE) && !pfx_full) begin
        pfx_mask_q[pfx_cnt_q[PIDX_W-1:0]] <= new_mask;
        pfx_addr_q[pfx_cnt_q[PIDX_W-1:0]] <= addr_q & new_mask;
      end
      if ((func_q == FUNC_ADD_OPEN) && proto_ok && !open_full) begin
        open_q[open_cnt_q[QIDX_W-1:0]] <= key;
      end
      if ((func_q == FUNC_ADD_RSTR) && proto_ok && !rstr_full) begin
        rstr_q[rstr_cnt_q[QIDX_W-1:0]] <= key;
      end
    end
  end

  // fill counts and overflow
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pfx_cnt_q  <= '0;
      open_cnt_q <= '0;
      rstr_cnt_q <= '0;
      ovf_q      <= 1'b0;
    end else if (cmd_i.exec) begin
      unique case (func_q)
        FUNC_ADD_SOURCE: begin
          if (pfx_full) begin
            ovf_q <= 1'b1;
          end else begin
            pfx_cnt_q <= PCNT_W'(pfx_cnt_q + 1'b1);
          end
        end
        FUNC_ADD_OPEN: begin
          if (proto_ok) begin
            if (open_full) begin
              ovf_q <= 1'b1;
            end else begin
              open_cnt_q <= QCNT_W'(open_cnt_q + 1'b1);
            end
          end
        end
        FUNC_ADD_RSTR: begin
          if (proto_ok) begin
            if (rstr_full) begin
              ovf_q <= 1'b1;
            end else begin
              rstr_cnt_q <= QCNT_W'(rstr_cnt_q + 1'b1);
            end
          end
        end
        FUNC_CLEAR: begin
          pfx_cnt_q  <= '0;
          open_cnt_q <= '0;
          rstr_cnt_q <= '0;
          ovf_q      <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // request totals
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q  <= '0;
      hits_q <= '0;
      rhit_q <= 1'b0;
    end else if (cmd_i.exec && (func_q == FUNC_CLEAR)) begin
      req_q  <= '0;
      hits_q <= '0;
      rhit_q <= 1'b0;
    end else if (cmd_i.finish) begin
      if (req_q != COUNTER_MAX) begin
        req_q <= CNT_W'(req_q + 1'b1);
      end
      hits_q <= (hits_sum > (CNT_W + 1)'(COUNTER_MAX)) ? COUNTER_MAX : hits_sum[CNT_W-1:0];
      rhit_q <= rhit_q | rstr_any_q;
    end else if (cmd_i.emit && (func_q == FUNC_PAIR)) begin
      req_q  <= '0;
      hits_q <= '0;
      rhit_q <= 1'b0;
    end
  end

  // scan counter and per-item hit flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      found_q    <= 1'b0;
      open_sum_q <= '0;
      rstr_any_q <= 1'b0;
    end else if (cmd_i.exec) begin
      idx_q      <= '0;
      found_q    <= 1'b0;
      open_sum_q <= '0;
      rstr_any_q <= 1'b0;
    end else if (cmd_i.step) begin
      idx_q <= idx_next;
      if (func_q == FUNC_CHECK) begin
        found_q <= found_q | pfx_hit;
      end else begin
        if (open_hit) begin
          open_sum_q <= QCNT_W'(open_sum_q + 1'b1);
        end
        rstr_any_q <= rstr_any_q | rstr_hit;
      end
    end
  end

  // result register: drains independently of the controller
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_kind_q <= (func_q == FUNC_CHECK) ? KIND_ADDRESS : KIND_PORT;
      out_data_q <= {{(OUT_DATA_W - 2){1'b0}}, ovf_q,
                     (func_q == FUNC_CHECK) ? found_q : verdict};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_kind_o  = out_kind_q;

  assign stat_o.func       = func_q;
  assign stat_o.proto_ok   = proto_ok;
  assign stat_o.last       = last_q;
  assign stat_o.scan_empty = (limit == '0);
  assign stat_o.scan_done  = (idx_next == limit);
  assign stat_o.out_free   = out_free;

endmodule

// File: src/source_and_port_access_check.sv
// ----------------------------------------------------------------------------
// Source prefix and port access check
// Keeps source prefix, open pair and restricted pair tables and answers
// address checks and multi-word port requests.
// ----------------------------------------------------------------------------
// One input word is processed at a time. Adds, clears and unused codes are
// captured and executed; an address check is captured, executed, scanned over
// the N stored prefixes and emitted; a requested pair is captured, executed,
// scanned over M entries, M being the larger of the open and restricted fill
// counts, and folded into the request totals, then emitted when it closes the
// request. The scan counter compares one entry of the 16-entry tables per
// cycle. The result sits in an output register, so a stalled result does not
// block the next input word unless that word needs to deliver a result as well.
module source_and_port_access_check import spacl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // address[31:0], prefix_len[37:32], protocol[39:38], port_number[55:40]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // func[2:0]
  input  logic [FUNC_W-1:0]     s_axis_tuser_i,
  input  logic                  s_axis_tlast_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // granted[0], overflow[1], zero[7:2]
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // result_kind[0]
  output logic                  m_axis_tuser_o
);

  spacl_cmd_t  cmd;
  spacl_stat_t stat;

  spacl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  spacl_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (s_axis_tdata_i),
    .in_func_i   (s_axis_tuser_i),
    .in_last_i   (s_axis_tlast_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_kind_o  (m_axis_tuser_o)
  );

endmodule

// File: src/spacl_checker.sv
// ----------------------------------------------------------------------------
// Access check port checker
// Watches the top-level ports for handshake and sequencing errors.
// ----------------------------------------------------------------------------
module spacl_checker import spacl_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid_i,
  input logic                  s_axis_tready_o,
  input logic [FUNC_W-1:0]     s_axis_tuser_i,
  input logic                  s_axis_tlast_i,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic                  m_axis_tuser_o
);

  logic in_acc;
  logic no_result;

  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  // words that never yield a result
  assign no_result = (s_axis_tuser_i != FUNC_CHECK) &&
                     ((s_axis_tuser_i != FUNC_PAIR) || !s_axis_tlast_i);

  // stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // one word at a time: busy right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready_o)
    else $error("input accepted while busy");

  // adds, clears, unused codes and non-final pairs raise no result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && no_result |=> !$rose(m_axis_tvalid_o) ##1 !$rose(m_axis_tvalid_o))
    else $error("unexpected result");

  // padding bits of the result stay zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[OUT_DATA_W-1:2] == '0))
    else $error("nonzero result padding");

endmodule

bind source_and_port_access_check spacl_checker u_checker (.*);
